// File: src/potos_pkg.sv
// Shared types, constants and codes of the per-query top-K overlap suppression block.
package potos_pkg;

   localparam int POTOS_TOPK        = 16;
   localparam int POTOS_NUM_QUERIES = 64;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_INSERT  = 3'd1,
      ACT_REPLACE = 3'd2,
      ACT_SHIFT   = 3'd3,
      ACT_REJECT  = 3'd4
   } potos_action_type;

   typedef struct packed {
      logic [5:0]  query_index;
      logic [23:0] first_index;
      logic [23:0] second_index;
      logic [31:0] distance;
      logic [15:0] file_id;
      logic [30:0] cand_start;
      logic [30:0] cand_end;
      logic [23:0] subseq_id;
      logic        out_of_range;
   } potos_item_type;

   // front to back: head of the item queue
   typedef struct packed {
      logic           valid;
      potos_item_type item;
   } potos_head_type;

   // back to front
   typedef struct packed {
      logic take;
      logic clearing;
   } potos_stat_type;

   typedef struct packed {
      logic [31:0] distance;
      logic [23:0] first_index;
      logic [23:0] second_index;
      logic [31:0] start_t;
      logic [31:0] end_t;
      logic [15:0] file;
      logic        new_mark;
      logic [23:0] subseq_id;
   } potos_entry_type;

   localparam potos_entry_type ENTRY_RESET = '{
      distance: '1, first_index: '0, second_index: '0, start_t: '1, end_t: '1,
      file: '1, new_mark: 1'b0, subseq_id: '0};

endpackage

// File: src/potos_front.sv
// Input side: accepts candidates, flags out-of-range queries, two-entry queue to the back end.
module potos_front
   import potos_pkg::*;
#(
   parameter int NUM_QUERIES = POTOS_NUM_QUERIES
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   output logic           req_full,
   input  logic [5:0]     req_query_index,
   input  logic [23:0]    req_first_index,
   input  logic [23:0]    req_second_index,
   input  logic [31:0]    req_distance,
   input  logic [15:0]    req_file_id,
   input  logic [30:0]    req_cand_start,
   input  logic [30:0]    req_cand_end,
   input  logic [23:0]    req_subseq_id,
   input  potos_stat_type stat,
   output potos_head_type head
);

   potos_item_type slot_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok;
   potos_item_type new_item;

   assign req_full = (cnt_ff == 2'd2) || stat.clearing;
   assign push_ok  = req_push && !req_full;

   always_comb begin
      new_item.query_index  = req_query_index;
      new_item.first_index  = req_first_index;
      new_item.second_index = req_second_index;
      new_item.distance     = req_distance;
      new_item.file_id      = req_file_id;
      new_item.cand_start   = req_cand_start;
      new_item.cand_end     = req_cand_end;
      new_item.subseq_id    = req_subseq_id;
      new_item.out_of_range = 32'(req_query_index) >= NUM_QUERIES;
   end

   always_comb begin
      wp_in  = wp_ff ^ push_ok;
      rp_in  = rp_ff ^ stat.take;
      cnt_in = cnt_ff + 2'(push_ok) - 2'(stat.take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) slot_ff[wp_ff] <= new_item;
   end

   assign head.valid = cnt_ff != 2'd0;
   assign head.item  = slot_ff[rp_ff];

endmodule

// File: src/potos_back.sv
// Back end: list memory, scan/shift/write sequencer and two-entry result queue.
module potos_back
   import potos_pkg::*;
#(
   parameter int TOPK        = POTOS_TOPK,
   parameter int NUM_QUERIES = POTOS_NUM_QUERIES
) (
   input  logic             clock,
   input  logic             reset,
   input  potos_head_type   head,
   output potos_stat_type   stat,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [31:0]      rsp_kth_distance,
   output logic [2:0]       rsp_action
);

   localparam int DEPTH = NUM_QUERIES * TOPK;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW    = (TOPK > 1) ? $clog2(TOPK) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(TOPK - 1);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_SCAN   = 8'b0000_0100,
      ST_DECIDE = 8'b0000_1000,
      ST_SHIFT  = 8'b0001_0000,
      ST_DRAIN  = 8'b0010_0000,
      ST_WRITE  = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic [31:0]      kth;
      potos_action_type act;
   } result_type;

   state_type state_ff, state_in;

   potos_entry_type mem [DEPTH];
   potos_entry_type rd_data_ff;
   logic [AW-1:0]   rd_addr;
   logic            we;
   logic [AW-1:0]   wa;
   potos_entry_type wd;

   logic [AW-1:0]  clr_ff, clr_in;
   potos_item_type cand_ff, cand_in;
   logic [AW-1:0]  base_ff, base_in;
   logic [IW-1:0]  iss_ff, iss_in;
   logic           iss_done_ff, iss_done_in;
   logic           scan_rv_ff, scan_rv_in;
   logic           shift_rv_ff, shift_rv_in;
   logic [IW-1:0]  ridx_ff, ridx_in;
   logic           sf_ff, sf_in, mf_ff, mf_in;
   logic [IW-1:0]  sp_ff, sp_in, mp_ff, mp_in;
   logic [31:0]    dlast_ff, dlast_in, dprev_ff, dprev_in;
   logic [IW-1:0]  last_ff, last_in;
   result_type     res_ff, res_in;

   result_type res_q_ff [2];
   logic       rwp_ff, rrp_ff;
   logic [1:0] rcnt_ff;
   logic       res_push, res_pop;
   result_type res_push_data;

   logic       hit_sort, hit_match;
   logic [32:0] da, db;
   logic       pa, na, pb, nb;

   // overlap test from the signs of the two differences
   always_comb begin
      da = $signed({rd_data_ff.end_t[31], rd_data_ff.end_t}) - $signed({2'b00, cand_ff.cand_start});
      db = $signed({2'b00, cand_ff.cand_end}) - $signed({rd_data_ff.start_t[31], rd_data_ff.start_t});
      pa = !da[32] && (da != '0);
      na = da[32];
      pb = !db[32] && (db != '0);
      nb = db[32];
      hit_sort  = rd_data_ff.distance > cand_ff.distance;
      hit_match = (rd_data_ff.file == cand_ff.file_id) && ((pa && pb) || (na && nb));
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      cand_in     = cand_ff;
      base_in     = base_ff;
      iss_in      = iss_ff;
      iss_done_in = iss_done_ff;
      scan_rv_in  = 1'b0;
      shift_rv_in = 1'b0;
      ridx_in     = iss_ff;
      sf_in       = sf_ff;
      mf_in       = mf_ff;
      sp_in       = sp_ff;
      mp_in       = mp_ff;
      dlast_in    = dlast_ff;
      dprev_in    = dprev_ff;
      last_in     = last_ff;
      res_in      = res_ff;
      rd_addr     = base_ff + AW'(iss_ff);
      stat.take     = 1'b0;
      stat.clearing = state_ff == ST_CLEAR;
      res_push    = 1'b0;
      res_push_data = res_ff;

      if (scan_rv_ff) begin
         if (!sf_ff && hit_sort) begin
            sf_in = 1'b1;
            sp_in = ridx_ff;
         end
         if (!mf_ff && hit_match) begin
            mf_in = 1'b1;
            mp_in = ridx_ff;
         end
         if (ridx_ff == LAST_IDX) dlast_in = rd_data_ff.distance;
         if (TOPK > 1 && ridx_ff == IW'(TOPK - 2)) dprev_in = rd_data_ff.distance;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (head.valid && rcnt_ff != 2'd2) begin
               stat.take = 1'b1;
               if (head.item.out_of_range) begin
                  res_push          = 1'b1;
                  res_push_data.kth = '1;
                  res_push_data.act = ACT_NONE;
               end else begin
                  cand_in     = head.item;
                  base_in     = AW'(head.item.query_index) * AW'(TOPK);
                  iss_in      = '0;
                  iss_done_in = 1'b0;
                  sf_in       = 1'b0;
                  mf_in       = 1'b0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (!iss_done_ff) begin
               scan_rv_in = 1'b1;
               if (iss_ff == LAST_IDX) iss_done_in = 1'b1;
               else iss_in = iss_ff + 1'b1;
            end
            if (scan_rv_ff && ridx_ff == LAST_IDX) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            priority if (!sf_ff) begin
               res_in.act = ACT_NONE;
               res_in.kth = dlast_ff;
               state_in   = ST_DONE;
            end else if (mf_ff && mp_ff < sp_ff) begin
               res_in.act = ACT_REJECT;
               res_in.kth = dlast_ff;
               state_in   = ST_DONE;
            end else begin
               if (!mf_ff) begin
                  res_in.act = ACT_INSERT;
                  last_in    = LAST_IDX;
               end else if (mp_ff == sp_ff) begin
                  res_in.act = ACT_REPLACE;
                  last_in    = sp_ff;
               end else begin
                  res_in.act = ACT_SHIFT;
                  last_in    = mp_ff;
               end
               if (last_in != LAST_IDX) res_in.kth = dlast_ff;
               else if (sp_ff == LAST_IDX) res_in.kth = cand_ff.distance;
               else res_in.kth = dprev_ff;
               iss_in = last_in - 1'b1;
               if (last_in > sp_ff) state_in = ST_SHIFT;
               else state_in = ST_WRITE;
            end
         end
         ST_SHIFT: begin
            // read slot i-1 now; the registered copy is written to slot i in the next cycle
            shift_rv_in = 1'b1;
            if (iss_ff == sp_ff) state_in = ST_DRAIN;
            else iss_in = iss_ff - 1'b1;
         end
         ST_DRAIN: state_in = ST_WRITE;
         ST_WRITE: state_in = ST_DONE;
         ST_DONE: begin
            res_push = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      we = 1'b0;
      wa = base_ff + AW'(sp_ff);
      wd.distance     = cand_ff.distance;
      wd.first_index  = cand_ff.first_index;
      wd.second_index = cand_ff.second_index;
      wd.start_t      = {1'b0, cand_ff.cand_start};
      wd.end_t        = {1'b0, cand_ff.cand_end};
      wd.file         = cand_ff.file_id;
      wd.new_mark     = 1'b1;
      wd.subseq_id    = cand_ff.subseq_id;
      priority if (state_ff == ST_CLEAR) begin
         we = 1'b1;
         wa = clr_ff;
         wd = ENTRY_RESET;
      end else if (shift_rv_ff) begin
         we = 1'b1;
         wa = base_ff + AW'(ridx_ff) + 1'b1;
         wd = rd_data_ff;
      end else if (state_ff == ST_WRITE) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         scan_rv_ff  <= 1'b0;
         shift_rv_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         scan_rv_ff  <= scan_rv_in;
         shift_rv_ff <= shift_rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      base_ff     <= base_in;
      iss_ff      <= iss_in;
      iss_done_ff <= iss_done_in;
      ridx_ff     <= ridx_in;
      sf_ff       <= sf_in;
      mf_ff       <= mf_in;
      sp_ff       <= sp_in;
      mp_ff       <= mp_in;
      dlast_ff    <= dlast_in;
      dprev_ff    <= dprev_in;
      last_ff     <= last_in;
      res_ff      <= res_in;
   end

   // result queue
   assign res_pop = rsp_pop && (rcnt_ff != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rwp_ff  <= 1'b0;
         rrp_ff  <= 1'b0;
         rcnt_ff <= 2'd0;
      end else begin
         rwp_ff  <= rwp_ff ^ res_push;
         rrp_ff  <= rrp_ff ^ res_pop;
         rcnt_ff <= rcnt_ff + 2'(res_push) - 2'(res_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) res_q_ff[rwp_ff] <= res_push_data;
   end

   assign rsp_empty        = rcnt_ff == 2'd0;
   assign rsp_kth_distance = res_q_ff[rrp_ff].kth;
   assign rsp_action       = res_q_ff[rrp_ff].act;

endmodule

// File: src/per_query_topk_overlap_suppress.sv
// Top level of the per-query top-K list with overlap suppression.
//   channel  direction  handshake         beat
//   req_     in         push / full       one candidate
//   rsp_     out        pop / empty       kth distance and action
// An item goes through scan (one memory read a cycle), decide and finish, plus shift
// and drain steps when entries move and a write step when the list changes; the
// single list memory port serialises these, and the next candidate waits until done.
// Out-of-range queries skip the scan and push their result from the idle state.
// After reset a clearing pass writes all NUM_QUERIES*TOPK entries, one a cycle;
// req_full stays high meanwhile. A two-beat queue on each side lets the other stall.
module per_query_topk_overlap_suppress
   import potos_pkg::*;
#(
   parameter int TOPK        = POTOS_TOPK,
   parameter int NUM_QUERIES = POTOS_NUM_QUERIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [5:0]  req_query_index,
   input  logic [23:0] req_first_index,
   input  logic [23:0] req_second_index,
   input  logic [31:0] req_distance,
   input  logic [15:0] req_file_id,
   input  logic [30:0] req_cand_start,
   input  logic [30:0] req_cand_end,
   input  logic [23:0] req_subseq_id,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_kth_distance,
   output logic [2:0]  rsp_action
);

   potos_head_type head;
   potos_stat_type stat;

   potos_front #(.NUM_QUERIES(NUM_QUERIES)) u_front (
      .clock, .reset, .req_push, .req_full, .req_query_index, .req_first_index,
      .req_second_index, .req_distance, .req_file_id, .req_cand_start,
      .req_cand_end, .req_subseq_id, .stat, .head
   );

   potos_back #(.TOPK(TOPK), .NUM_QUERIES(NUM_QUERIES)) u_back (
      .clock, .reset, .head, .stat, .rsp_empty, .rsp_pop, .rsp_kth_distance, .rsp_action
   );

endmodule

// File: src/potos_checker.sv
// Port-level checks of the top level, bound to it.
module potos_checker
   import potos_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_kth_distance,
   input logic [2:0]  rsp_action
);

   // clearing pass holds off input right after reset
   a_full_after_reset: assert property (@(posedge clock) reset |=> req_full)
      else $error("req_full low right after reset");

   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

   a_action_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_action == ACT_NONE || rsp_action == ACT_INSERT ||
                      rsp_action == ACT_REPLACE || rsp_action == ACT_SHIFT ||
                      rsp_action == ACT_REJECT))
      else $error("bad action code");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_kth_distance) && $stable(rsp_action))
      else $error("stalled result changed");

endmodule

bind per_query_topk_overlap_suppress potos_checker u_potos_checker (
   .clock, .reset, .req_full, .rsp_empty, .rsp_pop, .rsp_kth_distance, .rsp_action
);
